[hdl/hbtm_pkg.sv]
// hbtm_pkg: shared types and constants for the heartbeat timeout monitor
// used by every module under hdl/, depends on nothing
package hbtm_pkg;

   localparam int TARGET_W    = 4;
   localparam int TIME_W      = 32;
   localparam int COUNT_W     = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int ADDRESSABLE = 16;

   localparam int NUM_TARGETS_DEFAULT = 16;

   localparam logic [COUNT_W-1:0] TARGET_COUNT_RESET = 5'd16;
   localparam logic [TIME_W-1:0]  TIMEOUT_RESET      = 32'd5000;

   // command codes
   localparam logic CMD_HEARTBEAT = 1'b0;
   localparam logic CMD_CHECK     = 1'b1;

   // register select, paddr bit 2
   localparam logic REG_TARGET_COUNT = 1'b0;
   localparam logic REG_TIMEOUT      = 1'b1;

   typedef struct packed {
      logic                command;
      logic [TARGET_W-1:0] target;
      logic [TIME_W-1:0]   now_ms;
   } req_type;

   typedef struct packed {
      logic [TARGET_W-1:0] target_id;
      logic                online;
      logic                last_of_run;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[hdl/heartbeat_timeout_monitor_unit.sv]
// heartbeat_timeout_monitor_unit: top level, config registers and block wiring
// depends on hbtm_pkg, hbtm_front, hbtm_queue, hbtm_engine
//
// Usage: request words arrive on req_valid/req_item/req_stall. A heartbeat word
// names a target and the current time in ms; the target is marked online and one
// response word {target, online=1, last_of_run=1} is returned. Heartbeats for a
// target at or above the active count are dropped with no response. A check word
// scans targets 0 .. count-1, one entry per cycle, and returns one response word
// {target, online=0} for each online target whose elapsed time exceeds timeout_ms;
// the final one carries last_of_run. A check with no timeouts returns nothing.
// Throughput: heartbeats run back to back at one per cycle while responses are
// not held by rsp_stall; a check holds the engine until its scan of the target
// table is done.
// A two-word queue lets new requests be taken while the scan runs.
// Registers: 0x0 target_count (reset 16), 0x4 timeout_ms (reset 5000); write only
// while idle. After reset every target is offline and the queue is empty.
// When rsp_stall is high the held response stays put; the scan runs on until a
// second report has to go out and then waits on it.
module heartbeat_timeout_monitor_unit
   import hbtm_pkg::*;
#(
   parameter int NUM_TARGETS = NUM_TARGETS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  req_type               req_item,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output rsp_type               rsp_item,
   input  logic                  rsp_stall,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int DEPTH = (NUM_TARGETS < ADDRESSABLE) ? NUM_TARGETS : ADDRESSABLE;
   localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(DEPTH);

   logic [COUNT_W-1:0] target_count_ff, target_count_in;
   logic [TIME_W-1:0]  timeout_ff, timeout_in;
   logic [COUNT_W-1:0] active;
   logic               csr_write;

   queue_status_type   q_status;
   logic               push;
   req_type            push_item;
   logic               q_pop;
   req_type            q_item;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign active    = (target_count_ff > DEPTH_COUNT) ? DEPTH_COUNT : target_count_ff;

   always_comb begin
      target_count_in = target_count_ff;
      timeout_in      = timeout_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_TARGET_COUNT: target_count_in = pwdata[COUNT_W-1:0];
            REG_TIMEOUT:      timeout_in      = pwdata[TIME_W-1:0];
            default:          target_count_in = target_count_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_TARGET_COUNT: prdata = CSR_DATA_W'(target_count_ff);
         REG_TIMEOUT:      prdata = CSR_DATA_W'(timeout_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_count_ff <= TARGET_COUNT_RESET;
         timeout_ff      <= TIMEOUT_RESET;
      end else begin
         target_count_ff <= target_count_in;
         timeout_ff      <= timeout_in;
      end
   end

   hbtm_front u_front (
      .req_valid (req_valid),
      .req_item  (req_item),
      .req_stall (req_stall),
      .active    (active),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   hbtm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (q_item),
      .q_status  (q_status)
   );

   hbtm_engine #(
      .NUM_TARGETS (NUM_TARGETS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .q_item     (q_item),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .active     (active),
      .timeout_ms (timeout_ff),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

   // an online report only comes from a heartbeat, which is always a single word
   a_online_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.online |-> rsp_item.last_of_run)
      else $error("online response without last_of_run");

   // reports only name targets inside the active range
   a_target_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_item.target_id} < active))
      else $error("response names a target outside the active range");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response word right after reset");

endmodule

[hdl/hbtm_front.sv]
// hbtm_front: accepts request words, drops heartbeats outside the active range
// depends on hbtm_pkg
module hbtm_front
   import hbtm_pkg::*;
(
   input  logic                   req_valid,
   input  req_type                req_item,
   output logic                   req_stall,
   input  logic [COUNT_W-1:0]     active,
   input  queue_status_type       q_status,
   output logic                   push,
   output req_type                push_item
);

   logic accepted;
   logic keep;

   assign req_stall = q_status.full;
   assign accepted  = req_valid && !q_status.full;
   assign keep      = (req_item.command == CMD_CHECK) ||
                      ({1'b0, req_item.target} < active);
   assign push      = accepted && keep;
   assign push_item = req_item;

endmodule

[hdl/hbtm_queue.sv]
// hbtm_queue: short fifo of classified request words between front and engine
// depends on hbtm_pkg
module hbtm_queue
   import hbtm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  req_type          push_item,
   input  logic             pop,
   output req_type          pop_item,
   output queue_status_type q_status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);

   req_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign q_status.full  = (count_ff == FULL_COUNT);
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign pop_item       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[hdl/hbtm_engine.sv]
// hbtm_engine: target table, heartbeat update and a timeout scan of one entry per cycle unless stalled
// depends on hbtm_pkg
module hbtm_engine
   import hbtm_pkg::*;
#(
   parameter int NUM_TARGETS = NUM_TARGETS_DEFAULT
)
(
   input  logic                clock,
   input  logic                reset,
   input  req_type             q_item,
   input  queue_status_type    q_status,
   output logic                q_pop,
   input  logic [COUNT_W-1:0]  active,
   input  logic [TIME_W-1:0]   timeout_ms,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output rsp_type             rsp_item
);

   localparam int DEPTH = (NUM_TARGETS < ADDRESSABLE) ? NUM_TARGETS : ADDRESSABLE;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic [TIME_W-1:0]  last_seen_ff [DEPTH];
   logic [DEPTH-1:0]   alive_ff, alive_in;
   logic               state_ff, state_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [IDX_W-1:0]   pend_ff, pend_in;
   logic               pend_valid_ff, pend_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               can_emit;
   logic               at_end;
   logic [IDX_W-1:0]   scan_idx;
   logic [IDX_W-1:0]   hb_idx;
   logic [TIME_W-1:0]  seen_rd;
   logic [TIME_W-1:0]  elapsed;
   logic               hit;
   logic               hb_write;

   assign can_emit  = !rsp_valid_ff || !rsp_stall;
   assign at_end    = (idx_ff == CNT_W'(active));
   assign scan_idx  = idx_ff[IDX_W-1:0];
   assign hb_idx    = q_item.target[IDX_W-1:0];
   assign seen_rd   = last_seen_ff[scan_idx];
   assign elapsed   = now_ff - seen_rd;
   assign hit       = !at_end && alive_ff[scan_idx] && (elapsed > timeout_ms);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      now_in        = now_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      alive_in      = alive_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      q_pop         = 1'b0;
      hb_write      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               if (q_item.command == CMD_HEARTBEAT) begin
                  if (can_emit) begin
                     q_pop              = 1'b1;
                     hb_write           = 1'b1;
                     alive_in[hb_idx]   = 1'b1;
                     rsp_in.target_id   = q_item.target;
                     rsp_in.online      = 1'b1;
                     rsp_in.last_of_run = 1'b1;
                     rsp_valid_in       = 1'b1;
                  end
               end else begin
                  q_pop         = 1'b1;
                  now_in        = q_item.now_ms;
                  idx_in        = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (at_end) begin
               // flush the held report as the last of the run
               if (!pend_valid_ff) begin
                  state_in = ST_IDLE;
               end else if (can_emit) begin
                  rsp_in.target_id   = TARGET_W'(pend_ff);
                  rsp_in.online      = 1'b0;
                  rsp_in.last_of_run = 1'b1;
                  rsp_valid_in       = 1'b1;
                  pend_valid_in      = 1'b0;
                  state_in           = ST_IDLE;
               end
            end else if (!hit) begin
               idx_in = idx_ff + 1'b1;
            end else if (!pend_valid_ff || can_emit) begin
               // one report is held back until we know whether another follows
               if (pend_valid_ff) begin
                  rsp_in.target_id   = TARGET_W'(pend_ff);
                  rsp_in.online      = 1'b0;
                  rsp_in.last_of_run = 1'b0;
                  rsp_valid_in       = 1'b1;
               end
               alive_in[scan_idx] = 1'b0;
               pend_in            = scan_idx;
               pend_valid_in      = 1'b1;
               idx_in             = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         alive_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         alive_ff      <= alive_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff  <= now_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
      if (hb_write) begin
         last_seen_ff[hb_idx] <= q_item.now_ms;
      end
   end

endmodule

[tb/heartbeat_timeout_monitor_unit_tb.sv]
// heartbeat_timeout_monitor_unit_tb: self-checking bench for the heartbeat watchdog top level
// walks a directed table, then random phases; results checked against an in-bench predictor
// depends on hbtm_pkg and heartbeat_timeout_monitor_unit
module heartbeat_timeout_monitor_unit_tb
   import hbtm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TARGETS = 16;
   localparam int SETTLE_CYCLES = 60;

   typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT, CHK_TYPED} check_kind_type;

   typedef struct {
      row_kind_type   kind;
      logic           sel;
      logic [31:0]    value;
      req_type        word;
      check_kind_type chk;
      rsp_type        typed;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   req_type               req_item = '0;
   logic                  req_stall;
   logic                  rsp_valid;
   rsp_type               rsp_item;
   logic                  rsp_stall = 1'b1;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // watchdog state as the bench sees it
   logic [TIME_W-1:0]  seen_ms [TARGETS];
   logic               online_map [TARGETS];
   logic [COUNT_W-1:0] limit_count = TARGET_COUNT_RESET;
   logic [TIME_W-1:0]  limit_ms = TIMEOUT_RESET;

   rsp_type        due_reports[$];
   rsp_type        scan_reports[$];
   plan_row_type   plan[$];
   check_kind_type cur_chk = CHK_MODEL;
   rsp_type        cur_typed = '0;
   bit             steady = 1'b0;
   int             mismatches = 0;

   heartbeat_timeout_monitor_unit #(.NUM_TARGETS(TARGETS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_item(req_item), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .rsp_stall(rsp_stall),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #10 clock = ~clock;

   initial begin
      #5_000_000;
      $display("heartbeat_timeout_monitor_unit test failed");
      $finish;
   end

   initial begin
      for (int i = 0; i < TARGETS; i++) begin
         seen_ms[i] = '0;
         online_map[i] = 1'b0;
      end
   end

   function automatic int active_targets();
      int n;
      n = int'(limit_count);
      if (n > TARGETS) n = TARGETS;
      if (n > ADDRESSABLE) n = ADDRESSABLE;
      return n;
   endfunction

   // fills scan_reports with the words one request should produce
   function automatic void watchdog_predict(input req_type w);
      int n;
      logic [TIME_W-1:0] elapsed;
      rsp_type r;
      scan_reports.delete();
      n = active_targets();
      if (w.command == CMD_HEARTBEAT) begin
         if (w.target < n) begin
            seen_ms[w.target] = w.now_ms;
            online_map[w.target] = 1'b1;
            r.target_id = w.target;
            r.online = 1'b1;
            r.last_of_run = 1'b1;
            scan_reports.insert(scan_reports.size(), r);
         end
      end else begin
         for (int i = 0; i < n; i++) begin
            elapsed = w.now_ms - seen_ms[i];
            if (online_map[i] && elapsed > limit_ms) begin
               online_map[i] = 1'b0;
               r.target_id = i[TARGET_W-1:0];
               r.online = 1'b0;
               r.last_of_run = 1'b0;
               scan_reports.insert(scan_reports.size(), r);
            end
         end
         if (scan_reports.size() != 0)
            scan_reports[scan_reports.size()-1].last_of_run = 1'b1;
      end
   endfunction

   // both channels observed at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && req_valid === 1'b1 && req_stall === 1'b0) begin
         watchdog_predict(req_item);
         case (cur_chk)
            CHK_MODEL: begin
               foreach (scan_reports[i]) due_reports.insert(due_reports.size(), scan_reports[i]);
            end
            CHK_TYPED: due_reports.insert(due_reports.size(), cur_typed);
            default: ;
         endcase
      end
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (due_reports.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word target_id %0d online %0b last_of_run %0b",
                     $time, rsp_item.target_id, rsp_item.online, rsp_item.last_of_run);
         end else begin
            want = due_reports.pop_front();
            if (rsp_item !== want) begin
               mismatches++;
               $display({"%0t: mismatch target_id exp %0d got %0d, online exp %0b got %0b,",
                         " last_of_run exp %0b got %0b"},
                        $time, want.target_id, rsp_item.target_id, want.online,
                        rsp_item.online, want.last_of_run, rsp_item.last_of_run);
            end
         end
      end
   end

   // receiver stalls for a random hold before each word, or not at all while steady
   initial begin
      int hold;
      @(negedge clock);
      forever begin
         hold = steady ? 0 : $urandom_range(0, 12);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
         @(negedge clock);
      end
   end

   function automatic void put_write(input logic sel, input logic [31:0] v);
      plan_row_type row;
      row.kind = ROW_WRITE;
      row.sel = sel;
      row.value = v;
      row.word = '0;
      row.chk = CHK_SILENT;
      row.typed = '0;
      plan.insert(plan.size(), row);
   endfunction

   function automatic void put_word(input logic cmd, input logic [3:0] t,
                                    input logic [31:0] now, input check_kind_type c);
      plan_row_type row;
      row.kind = ROW_WORD;
      row.sel = 1'b0;
      row.value = '0;
      row.word.command = cmd;
      row.word.target = t;
      row.word.now_ms = now;
      row.chk = c;
      row.typed.target_id = t;
      row.typed.online = 1'b1;
      row.typed.last_of_run = 1'b1;
      plan.insert(plan.size(), row);
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_word(input req_type w, input check_kind_type c, input rsp_type r);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item <= w;
      cur_chk <= c;
      cur_typed <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid === 1'b1 && req_stall === 1'b0));
      @(negedge clock);
   endtask

   // drain everything, then give silent scans time to finish
   task automatic settle();
      req_valid <= 1'b0;
      while (due_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic sel, input logic [31:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {sel, 2'b00};
      pwdata <= v;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (sel == REG_TARGET_COUNT) limit_count = v[COUNT_W-1:0];
      else limit_ms = v;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   initial begin
      int n, r;
      logic [COUNT_W-1:0] cnt;
      logic [31:0] tmo, ms_clock;
      req_type w;

      // reset defaults: 16 targets, 5000 ms
      put_word(CMD_CHECK, 4'hA, 32'd0, CHK_SILENT);              // nothing online yet
      put_word(CMD_HEARTBEAT, 4'd0, 32'd0, CHK_TYPED);
      put_word(CMD_HEARTBEAT, 4'd15, 32'hFFFF_FFFF, CHK_TYPED);
      put_word(CMD_HEARTBEAT, 4'd5, 32'd1000, CHK_TYPED);
      put_word(CMD_HEARTBEAT, 4'd5, 32'd2000, CHK_TYPED);        // already online
      put_word(CMD_CHECK, 4'h0, 32'd5000, CHK_MODEL);            // exactly at the limit for 0
      put_word(CMD_CHECK, 4'hF, 32'd7001, CHK_MODEL);
      put_write(REG_TIMEOUT, 32'd0);
      put_word(CMD_HEARTBEAT, 4'd3, 32'd100, CHK_TYPED);
      put_word(CMD_CHECK, 4'h3, 32'd100, CHK_MODEL);             // zero elapsed stays online
      put_word(CMD_CHECK, 4'h3, 32'd101, CHK_MODEL);
      put_word(CMD_HEARTBEAT, 4'd9, 32'd200, CHK_TYPED);
      put_write(REG_TARGET_COUNT, 32'd0);
      put_word(CMD_HEARTBEAT, 4'd0, 32'd300, CHK_SILENT);        // no target in use
      put_word(CMD_CHECK, 4'h0, 32'd400, CHK_SILENT);
      put_write(REG_TARGET_COUNT, 32'd4);
      put_word(CMD_HEARTBEAT, 4'd4, 32'd500, CHK_SILENT);        // just beyond the count
      put_word(CMD_HEARTBEAT, 4'd3, 32'h8000_0000, CHK_TYPED);
      put_write(REG_TIMEOUT, 32'hFFFF_FFFF);
      put_word(CMD_CHECK, 4'h5, 32'h7FFF_FFFF, CHK_MODEL);       // largest elapsed, not beyond
      put_write(REG_TARGET_COUNT, 32'd31);
      put_write(REG_TIMEOUT, 32'd1);
      put_word(CMD_HEARTBEAT, 4'd15, 32'd10, CHK_TYPED);
      put_word(CMD_HEARTBEAT, 4'd14, 32'd20, CHK_TYPED);
      // beats later than now wrap; entry 9 kept its state while hidden
      put_word(CMD_CHECK, 4'h9, 32'd5, CHK_MODEL);

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            settle();
            csr_write(plan[i].sel, plan[i].value);
         end else begin
            send_word(plan[i].word, plan[i].chk, plan[i].typed);
         end
      end

      for (int p = 0; p < 5; p++) begin
         settle();
         case (p)
            0: begin cnt = 5'd16; tmo = $urandom_range(200, 3000); end
            1: begin cnt = 5'd1; tmo = 32'd0; end
            2: begin cnt = COUNT_W'($urandom_range(2, 15)); tmo = $urandom_range(200, 3000); end
            3: begin cnt = 5'd31; tmo = $urandom_range(1, 3000); end
            default: begin cnt = COUNT_W'($urandom_range(17, 30)); tmo = 32'hFFFF_FFFF; end
         endcase
         steady = (p == 1 || p == 4);
         csr_write(REG_TARGET_COUNT, {27'd0, cnt});
         csr_write(REG_TIMEOUT, tmo);
         ms_clock = $urandom();
         n = active_targets();
         for (int k = 0; k < 21; k++) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
               // noise: any time, any target
               w.command = 1'($urandom_range(0, 1));
               w.target = TARGET_W'($urandom_range(0, 15));
               w.now_ms = $urandom();
            end else begin
               ms_clock = ms_clock + $urandom_range(0, 1500);
               w.command = (r < 40) ? CMD_CHECK : CMD_HEARTBEAT;
               w.target = TARGET_W'($urandom_range(0, n - 1));
               w.now_ms = ms_clock;
            end
            send_word(w, CHK_MODEL, '0);
         end
      end

      req_valid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && due_reports.size() == 0)
         $display("heartbeat_timeout_monitor_unit test passed");
      else
         $display("heartbeat_timeout_monitor_unit test failed");
      $finish;
   end

endmodule
